[hdl/mbrx_pkg.sv]
// Package: types, constants and CRC-16/Modbus nibble table for the frame receiver.
`timescale 1ns / 1ps

package mbrx_pkg;

	// Frame buffer capacity and derived count width
	localparam int FRAME_CAPACITY = 64;
	localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);

	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] TIMER_MAX    = 16'hFFFF;
	localparam logic [7:0]  STATION_RST  = 8'd1;
	localparam logic [7:0]  ALTERNATE_RST = 8'd2;
	localparam logic [15:0] SILENCE_RST  = 16'd500;

	// Input item opcodes
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	// Result kinds
	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_STATION   = 2'd0,
		REG_ALTERNATE = 2'd1,
		REG_SILENCE   = 2'd2,
		REG_UNUSED    = 2'd3
	} cfg_reg_t;

	// One result item as produced by the frame core
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [5:0]  byte_index;
		logic [6:0]  frame_length;
		logic        crc_ok;
		logic        overflow;
	} result_t;

	// Reflected 0xA001 polynomial, one nibble step
	function automatic logic [15:0] crc_nib(input logic [3:0] idx);
		logic [15:0] v;
		case (idx)
			4'h0: v = 16'h0000;
			4'h1: v = 16'hCC01;
			4'h2: v = 16'hD801;
			4'h3: v = 16'h1400;
			4'h4: v = 16'hF001;
			4'h5: v = 16'h3C00;
			4'h6: v = 16'h2800;
			4'h7: v = 16'hE401;
			4'h8: v = 16'hA001;
			4'h9: v = 16'h6C00;
			4'hA: v = 16'h7800;
			4'hB: v = 16'hB401;
			4'hC: v = 16'h5000;
			4'hD: v = 16'h9C01;
			4'hE: v = 16'h8801;
			4'hF: v = 16'h4400;
			default: v = 16'h0000;
		endcase
		return v;
	endfunction

	// Fold one byte into the CRC, low nibble first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc_nib(b[3:0] ^ crc[3:0]) ^ (crc >> 4);
		c = crc_nib(b[7:4] ^ c[3:0]) ^ (c >> 4);
		return c;
	endfunction

endpackage

[hdl/mbrx_frame_core.sv]
// Frame state: byte count, silence timer, running CRC, overflow; one item per step.
`timescale 1ns / 1ps

module mbrx_frame_core import mbrx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  opcode_t     opcode,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  station_address,
	input  logic [7:0]  alternate_address,
	input  logic [15:0] silence_limit,
	output result_t     res
);

	logic [CNT_W-1:0] count_q;
	logic [15:0]      timer_q;
	logic [15:0]      crc_q;
	logic             ovf_q;

	logic [CNT_W-1:0] count_d;
	logic [15:0]      timer_d;
	logic [15:0]      crc_d;
	logic             ovf_d;

	logic full;
	logic take;
	logic expired;

	assign full    = (count_q >= CNT_W'(FRAME_CAPACITY));
	assign take    = (count_q != '0) || (rx_byte == station_address) ||
		(rx_byte == alternate_address);
	assign expired = (timer_q > silence_limit) || (timer_q == TIMER_MAX);

	// Result and next state for the item in hand
	always_comb begin
		count_d = count_q;
		timer_d = timer_q;
		crc_d   = crc_q;
		ovf_d   = ovf_q;
		res     = '0;
		res.kind = KIND_BYTE;
		case (opcode)
			OP_BYTE: begin
				timer_d = 16'd1;
				if (full) begin
					ovf_d = 1'b1;
				end else if (take) begin
					res.valid      = 1'b1;
					res.kind       = KIND_BYTE;
					res.data_byte  = rx_byte;
					res.byte_index = 6'(count_q);
					crc_d          = crc_fold(crc_q, rx_byte);
					count_d        = count_q + CNT_W'(1);
				end
			end
			OP_TICK: begin
				if (timer_q != '0) begin
					if (expired) begin
						res.valid        = 1'b1;
						res.kind         = KIND_END;
						res.frame_length = 7'(count_q);
						res.crc_ok       = (count_q != '0) && (crc_q == '0);
						res.overflow     = ovf_q;
						count_d = '0;
						timer_d = '0;
						crc_d   = CRC_INIT;
						ovf_d   = 1'b0;
					end else begin
						timer_d = timer_q + 16'd1;
					end
				end
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			timer_q <= '0;
			crc_q   <= CRC_INIT;
			ovf_q   <= 1'b0;
		end else if (step) begin
			count_q <= count_d;
			timer_q <= timer_d;
			crc_q   <= crc_d;
			ovf_q   <= ovf_d;
		end
	end

	// Checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FRAME_CAPACITY))
		else $error("byte count past capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CNT_W'(FRAME_CAPACITY)))
		else $error("overflow set on a frame that is not full");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.kind == KIND_END) |=>
		(count_q == '0 && timer_q == '0 && crc_q == CRC_INIT && !ovf_q))
		else $error("frame state not cleared after frame end");

	a_no_end_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(timer_q == '0) |-> !(res.valid && res.kind == KIND_END))
		else $error("frame end with timer stopped");

	a_byte_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && opcode == OP_BYTE) |=> (timer_q == 16'd1))
		else $error("byte did not restart silence timer");

endmodule

[hdl/modbus_rtu_frame_receiver_core.sv]
// Top level: input register, config registers, frame core and output register.
`timescale 1ns / 1ps

// Modbus RTU frame receiver.
// Input channel (in_valid / in_stall): opcode 0 carries a received byte in
// rx_byte, opcode 1 is one time tick. Output channel (out_valid / out_stall)
// carries either an accepted frame byte with its index, or a frame end with
// length, CRC-16/Modbus check and overflow flag.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// station address, 1 alternate address, 2 silence limit; other indexes are
// ignored. cfg_ready is always high; write only while the block is idle.
// Flow: an accepted item is held in the input register, and the frame update
// then loads its result into the output register.
// Throughput: one item per cycle while the output is not stalled.
// Stall: the output register holds a result while out_valid is stalled; one
// more item is held in the input register, and items that give no result
// still pass. in_stall rises only when the input register cannot drain.
// Reset: asynchronous, clears the frame (count 0, timer stopped, CRC 0xFFFF)
// and loads the address and silence registers with 1, 2 and 500.
module modbus_rtu_frame_receiver_core import mbrx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [7:0]  data_byte,
	output logic [5:0]  byte_index,
	output logic [6:0]  frame_length,
	output logic        crc_ok,
	output logic        overflow,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  station_q;
	logic [7:0]  alternate_q;
	logic [15:0] silence_q;

	logic        valid_s1;
	opcode_t     opcode_s1;
	logic [7:0]  byte_s1;

	logic        out_valid_q;
	result_t     out_q;
	result_t     res;
	logic        out_free;
	logic        step;
	logic        in_take;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q   <= STATION_RST;
			alternate_q <= ALTERNATE_RST;
			silence_q   <= SILENCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_STATION:   station_q   <= cfg_data[7:0];
				REG_ALTERNATE: alternate_q <= cfg_data[7:0];
				REG_SILENCE:   silence_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: s1 drains when output is free or the item gives no result
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && (out_free || !res.valid);
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1 <= opcode_t'(opcode);
			byte_s1   <= rx_byte;
		end
	end

	mbrx_frame_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.opcode            (opcode_s1),
		.rx_byte           (byte_s1),
		.station_address   (station_q),
		.alternate_address (alternate_q),
		.silence_limit     (silence_q),
		.res               (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign data_byte    = out_q.data_byte;
	assign byte_index   = out_q.byte_index;
	assign frame_length = out_q.frame_length;
	assign crc_ok       = out_q.crc_ok;
	assign overflow     = out_q.overflow;

endmodule
